// File: hw/rtl/utf8sd_pkg.sv
package utf8sd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 21;
    localparam int unsigned LenW  = 3;

    typedef enum logic [2:0] {
        CLS_CONT  = 3'd0,
        CLS_ASCII = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_BAD   = 3'd5
    } byte_class_t;

    typedef struct packed {
        logic [CodeW-1:0] code_point;
        logic             is_invalid;
        logic [LenW-1:0]  seq_bytes;
    } result_t;

    function automatic byte_class_t lead_class(input logic [4:0] top_bits);
        byte_class_t cls;
        begin
            cls = CLS_BAD;
            unique case (top_bits[4:3])
                2'b00, 2'b01: cls = CLS_ASCII;
                2'b10:        cls = CLS_CONT;
                2'b11:
                begin
                    unique case (top_bits[2:0])
                        3'b000, 3'b001, 3'b010, 3'b011: cls = CLS_LEAD2;
                        3'b100, 3'b101:                 cls = CLS_LEAD3;
                        3'b110:                         cls = CLS_LEAD4;
                        3'b111:                         cls = CLS_BAD;
                        default:                        cls = CLS_BAD;
                    endcase
                end
                default:      cls = CLS_BAD;
            endcase
            return cls;
        end
    endfunction

endpackage

// File: hw/rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder.
// Input channel: text_valid / text_ready carry one text_byte per transaction.
// Output channel: result_valid / result_ready carry one decoded character per
// transaction: code_point, is_invalid (malformed sequence, code_point zero)
// and seq_bytes (bytes consumed, 1 to 4).
// Only the last byte of a sequence, an ASCII byte, a stray continuation byte
// or a byte from 0xF8 up produces a transaction; a sequence still open when
// the text stops produces nothing until more bytes arrive.
// A last byte passes the input register and decode step to the output
// register. Throughput: 1 byte per cycle while the receiver is ready, set by
// the input register, the single decode step and the output register.
// Reset empties both registers and clears any open sequence.
// When the receiver stalls, the output register holds its result; the
// decode step then holds, and text_ready drops once the input register is
// full, so no byte and no result is ever lost.
module utf8_stream_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         text_valid,
    output logic                         text_ready,
    input  logic [utf8sd_pkg::ByteW-1:0] text_byte,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [utf8sd_pkg::CodeW-1:0] code_point,
    output logic                         is_invalid,
    output logic [utf8sd_pkg::LenW-1:0]  seq_bytes
);

    logic                         byte_valid;
    logic [utf8sd_pkg::ByteW-1:0] byte_data;
    logic                         can_take;
    logic                         advance;
    logic                         emit;
    utf8sd_pkg::result_t          result;
    utf8sd_pkg::result_t          result_q;

    assign advance = byte_valid && can_take;

    utf8sd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    utf8sd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .emit      (emit),
        .result    (result)
    );

    utf8sd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .emit         (emit),
        .result       (result),
        .can_take     (can_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_q     (result_q)
    );

    assign code_point = result_q.code_point;
    assign is_invalid = result_q.is_invalid;
    assign seq_bytes  = result_q.seq_bytes;

endmodule

// File: hw/rtl/utf8sd_in_stage.sv
module utf8sd_in_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [utf8sd_pkg::ByteW-1:0]   text_byte,
    input  logic                           advance,
    output logic                           byte_valid,
    output logic [utf8sd_pkg::ByteW-1:0]   byte_data
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [utf8sd_pkg::ByteW-1:0] byte_reg;
    logic                         load;

    assign text_ready = !valid_reg || advance;
    assign load       = text_valid && text_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= text_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// File: hw/rtl/utf8sd_decode.sv
module utf8sd_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [utf8sd_pkg::ByteW-1:0] byte_data,
    output logic                         emit,
    output utf8sd_pkg::result_t          result
);

    logic [1:0]                   pending_reg;
    logic [1:0]                   pending_next;
    logic [utf8sd_pkg::CodeW-1:0] partial_reg;
    logic [utf8sd_pkg::CodeW-1:0] partial_next;
    logic [utf8sd_pkg::LenW-1:0]  size_reg;
    logic [utf8sd_pkg::LenW-1:0]  size_next;
    logic                         bad_reg;
    logic                         bad_next;
    logic [utf8sd_pkg::CodeW-1:0] shifted;
    logic                         bad_acc;
    utf8sd_pkg::byte_class_t      cls;

    assign cls     = utf8sd_pkg::lead_class(byte_data[7:3]);
    assign shifted = {partial_reg[utf8sd_pkg::CodeW-7:0], byte_data[5:0]};
    assign bad_acc = bad_reg || (cls != utf8sd_pkg::CLS_CONT);

    always_comb
    begin
        pending_next      = pending_reg;
        partial_next      = partial_reg;
        size_next         = size_reg;
        bad_next          = bad_reg;
        emit              = 1'b0;
        result.code_point = '0;
        result.is_invalid = 1'b0;
        result.seq_bytes  = utf8sd_pkg::LenW'(1);
        if (pending_reg != 2'd0)
        begin
            pending_next = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                emit              = 1'b1;
                result.code_point = bad_acc ? '0 : shifted;
                result.is_invalid = bad_acc;
                result.seq_bytes  = size_reg;
                partial_next      = '0;
                size_next         = '0;
                bad_next          = 1'b0;
            end
            else
            begin
                partial_next = shifted;
                bad_next     = bad_acc;
            end
        end
        else
        begin
            unique case (cls)
                utf8sd_pkg::CLS_ASCII:
                begin
                    emit              = 1'b1;
                    result.code_point = {{(utf8sd_pkg::CodeW-8){1'b0}}, byte_data};
                end
                utf8sd_pkg::CLS_LEAD2:
                begin
                    partial_next = {{(utf8sd_pkg::CodeW-5){1'b0}}, byte_data[4:0]};
                    size_next    = utf8sd_pkg::LenW'(2);
                    pending_next = 2'd1;
                    bad_next     = 1'b0;
                end
                utf8sd_pkg::CLS_LEAD3:
                begin
                    partial_next = {{(utf8sd_pkg::CodeW-4){1'b0}}, byte_data[3:0]};
                    size_next    = utf8sd_pkg::LenW'(3);
                    pending_next = 2'd2;
                    bad_next     = 1'b0;
                end
                utf8sd_pkg::CLS_LEAD4:
                begin
                    partial_next = {{(utf8sd_pkg::CodeW-3){1'b0}}, byte_data[2:0]};
                    size_next    = utf8sd_pkg::LenW'(4);
                    pending_next = 2'd3;
                    bad_next     = 1'b0;
                end
                default:
                begin
                    emit              = 1'b1;
                    result.is_invalid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            size_reg    <= '0;
            bad_reg     <= 1'b0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            size_reg    <= size_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// File: hw/rtl/utf8sd_out_stage.sv
module utf8sd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                emit,
    input  utf8sd_pkg::result_t result,
    output logic                can_take,
    output logic                result_valid,
    input  logic                result_ready,
    output utf8sd_pkg::result_t result_q
);

    logic                valid_reg;
    logic                valid_next;
    utf8sd_pkg::result_t data_reg;
    logic                load;

    assign can_take = !valid_reg || result_ready;
    assign load     = advance && emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign result_q     = data_reg;

endmodule
